### src/assert_macros.svh
// Assertion helpers; every property is clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sbh_pkg.sv
`default_nettype none

package sbh_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SEED_X_LOW  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_X_HIGH = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_Y_LOW  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_Y_HIGH = CFG_INDEX_W'(3);

    typedef struct packed {
        logic [63:0] block_word0;
        logic [63:0] block_word1;
        logic [63:0] block_word2;
        logic [63:0] block_word3;
        logic        last_block;
    } sbh_in_t;

    typedef struct packed {
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } sbh_out_t;

    // Two 64-bit lanes, index 0 is the low lane.
    typedef logic [1:0][63:0] sbh_lanes_t;

    typedef struct packed {
        sbh_lanes_t x;
        sbh_lanes_t y;
    } sbh_state_t;

    function automatic logic [63:0] rot32(input logic [63:0] v);
        return {v[31:0], v[63:32]};
    endfunction

    function automatic sbh_lanes_t dword_rev(input sbh_lanes_t v);
        sbh_lanes_t r;
        r[0] = rot32(v[1]);
        r[1] = rot32(v[0]);
        return r;
    endfunction

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p;
    endfunction

    function automatic sbh_state_t mix_block(input sbh_state_t s, input sbh_lanes_t dx,
                                            input sbh_lanes_t dy);
        sbh_lanes_t x;
        sbh_lanes_t y;
        logic [63:0] mx0, mx1, my0, my1;
        sbh_state_t r;
        x[0] = s.x[0] ^ dx[0];
        x[1] = s.x[1] ^ dx[1];
        y[0] = s.y[0] - dy[0];
        y[1] = s.y[1] - dy[1];
        mx0 = mul32(x[0][31:0], y[0][63:32]);
        mx1 = mul32(x[1][31:0], y[1][63:32]);
        my0 = mul32(y[0][31:0], x[1][63:32]);
        my1 = mul32(y[1][31:0], x[0][63:32]);
        y = dword_rev(y);
        x[0] = x[0] - dy[0];
        x[1] = x[1] - dy[1];
        y[0] = y[0] + dx[0];
        y[1] = y[1] + dx[1];
        x = dword_rev(x);
        r.x[0] = x[0] - mx0;
        r.x[1] = x[1] - mx1;
        r.y[0] = y[0] - my0;
        r.y[1] = y[1] - my1;
        return r;
    endfunction

    function automatic sbh_out_t finalize(input sbh_state_t s);
        sbh_lanes_t x;
        sbh_lanes_t y;
        logic [63:0] mx0, mx1, my0, my1;
        sbh_out_t h;
        mx0 = mul32(s.x[0][31:0], s.y[1][63:32]);
        mx1 = mul32(s.x[1][31:0], s.y[0][63:32]);
        my0 = mul32(s.y[0][31:0], s.x[0][63:32]);
        my1 = mul32(s.y[1][31:0], s.x[1][63:32]);
        x = dword_rev(s.x);
        y = dword_rev(s.y);
        x[0] = x[0] + mx0;
        x[1] = x[1] + mx1;
        y[0] = y[0] - my0;
        y[1] = y[1] - my1;
        h.hash_low  = x[0] ^ y[0];
        h.hash_high = x[1] ^ y[1];
        return h;
    endfunction

endpackage

`default_nettype wire

### src/sbh_seed_regs.sv
`default_nettype none

module sbh_seed_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sbh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data,
    output sbh_pkg::sbh_state_t                 seed
);

    sbh_pkg::sbh_state_t seed_reg;
    sbh_pkg::sbh_state_t seed_next;

    assign cfg_ready = 1'b1;
    assign seed      = seed_reg;

    always_comb begin
        seed_next = seed_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sbh_pkg::REG_SEED_X_LOW:  seed_next.x[0] = cfg_data;
                sbh_pkg::REG_SEED_X_HIGH: seed_next.x[1] = cfg_data;
                sbh_pkg::REG_SEED_Y_LOW:  seed_next.y[0] = cfg_data;
                sbh_pkg::REG_SEED_Y_HIGH: seed_next.y[1] = cfg_data;
                // drop writes to unknown indexes
                default:                  seed_next = seed_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else begin
            seed_reg <= seed_next;
        end
    end

endmodule

`default_nettype wire

### src/sbh_mix_stage.sv
`default_nettype none

module sbh_mix_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sbh_pkg::sbh_in_t    s_data,
    input  wire sbh_pkg::sbh_state_t seed,
    output logic                     fin_valid,
    input  wire logic                fin_ready,
    output sbh_pkg::sbh_state_t      fin_state
);

    logic                in_valid_reg;
    logic                in_valid_next;
    sbh_pkg::sbh_in_t    in_reg;
    sbh_pkg::sbh_in_t    in_next;
    logic                open_reg;
    logic                open_next;
    sbh_pkg::sbh_state_t state_reg;
    sbh_pkg::sbh_state_t state_next;

    sbh_pkg::sbh_state_t src;
    sbh_pkg::sbh_state_t mixed;
    sbh_pkg::sbh_lanes_t dx;
    sbh_pkg::sbh_lanes_t dy;
    logic                take;

    always_comb begin
        // first block of a message starts from the seed
        src   = open_reg ? state_reg : seed;
        dx[0] = in_reg.block_word0;
        dx[1] = in_reg.block_word1;
        dy[0] = in_reg.block_word2;
        dy[1] = in_reg.block_word3;
        mixed = sbh_pkg::mix_block(src, dx, dy);

        // a last block waits until the finaliser has room
        take    = in_valid_reg && (!in_reg.last_block || fin_ready);
        s_ready = !in_valid_reg || take;

        in_valid_next = s_ready ? s_valid : in_valid_reg;
        in_next       = (s_ready && s_valid) ? s_data : in_reg;
        open_next     = take ? !in_reg.last_block : open_reg;
        state_next    = take ? mixed : state_reg;
    end

    assign fin_valid = in_valid_reg && in_reg.last_block;
    assign fin_state = mixed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            open_reg     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            open_reg     <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        state_reg <= state_next;
    end

endmodule

`default_nettype wire

### src/sbh_final_stage.sv
`default_nettype none

module sbh_final_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fin_valid,
    output logic                     fin_ready,
    input  wire sbh_pkg::sbh_state_t fin_state,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sbh_pkg::sbh_out_t        m_data
);

    logic                fv_reg;
    logic                fv_next;
    sbh_pkg::sbh_state_t fs_reg;
    sbh_pkg::sbh_state_t fs_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    sbh_pkg::sbh_out_t   m_data_reg;
    sbh_pkg::sbh_out_t   m_data_next;
    logic                out_free;

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        fin_ready = !fv_reg || out_free;

        fv_next = fin_ready ? fin_valid : fv_reg;
        fs_next = (fin_ready && fin_valid) ? fin_state : fs_reg;

        m_valid_next = out_free ? fv_reg : m_valid_reg;
        m_data_next  = (out_free && fv_reg) ? sbh_pkg::finalize(fs_reg) : m_data_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fv_reg      <= fv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fs_reg     <= fs_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### src/seeded_128bit_block_hash_unit.sv
// Channel   Ports                              Beat carries
// s_        s_valid s_ready s_data             one 32-byte block and its last flag
// m_        m_valid m_ready m_data             128-bit hash, one per last block
// cfg_      cfg_valid cfg_ready cfg_index/data seed register write
//
// One block is taken every cycle while s_ready is high; the rate is set by the
// 32x32 multipliers in the block mixing loop, which closes through the state register.
// A last block reaches its hash through the input register, which loads on the
// beat edge, then the finalise register, then the result register.
// Synchronous active-low reset clears the seeds, all valid flags and the open
// message flag. A non-last block leaves the input register on the next edge; a
// last block waits there while the finalise and result registers are both full
// and m_ready is low, and s_ready drops for that time.
`default_nettype none

`include "assert_macros.svh"

module seeded_128bit_block_hash_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sbh_pkg::sbh_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sbh_pkg::sbh_out_t                    m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sbh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]                     cfg_data
);

    sbh_pkg::sbh_state_t seed;
    sbh_pkg::sbh_state_t fin_state;
    logic                fin_valid;
    logic                fin_ready;

    sbh_seed_regs u_seed_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seed      (seed)
    );

    sbh_mix_stage u_mix_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .seed      (seed),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_state (fin_state)
    );

    sbh_final_stage u_final_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_state (fin_state),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `SBH_ASSERT_NXT(a_fin_hold, fin_valid && !fin_ready, fin_valid, "last block dropped")
    `SBH_ASSERT_IMP(a_stall_cause, !s_ready, m_valid && !m_ready, "stall without backpressure")
    `SBH_ASSERT_IMP(a_empty_flows, !m_valid, s_ready && fin_ready, "stall with empty output")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES  = 6;
    localparam int TAIL_CYCLES  = 20;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_BLOCKS = 110;

    typedef logic [63:0] word_t;

    class hash_scoreboard;
        word_t              seed[4];
        word_t              x0, x1, y0, y1;
        bit                 open_msg;
        sbh_pkg::sbh_out_t  hash_q[$];
        int                 err_count;

        function new();
            foreach (seed[i]) seed[i] = '0;
            open_msg  = 1'b0;
            err_count = 0;
            load_seed();
        endfunction

        function void load_seed();
            x0 = seed[0];
            x1 = seed[1];
            y0 = seed[2];
            y1 = seed[3];
        endfunction

        function word_t swap_halves(word_t w);
            return {w[31:0], w[63:32]};
        endfunction

        function word_t prod(logic [31:0] a, logic [31:0] b);
            return {32'b0, a} * {32'b0, b};
        endfunction

        function void write_seed(logic [sbh_pkg::CFG_INDEX_W-1:0] idx, word_t value);
            case (idx)
                sbh_pkg::REG_SEED_X_LOW:  seed[0] = value;
                sbh_pkg::REG_SEED_X_HIGH: seed[1] = value;
                sbh_pkg::REG_SEED_Y_LOW:  seed[2] = value;
                sbh_pkg::REG_SEED_Y_HIGH: seed[3] = value;
                default: ;
            endcase
        endfunction

        function void note_block(sbh_pkg::sbh_in_t blk);
            word_t             mx0, mx1, my0, my1, t;
            word_t             fx0, fx1, fy0, fy1;
            sbh_pkg::sbh_out_t h;
            // seeds are taken at the first beat of a message
            if (!open_msg) load_seed();
            x0 ^= blk.block_word0;
            x1 ^= blk.block_word1;
            y0 -= blk.block_word2;
            y1 -= blk.block_word3;
            mx0 = prod(x0[31:0], y0[63:32]);
            mx1 = prod(x1[31:0], y1[63:32]);
            my0 = prod(y0[31:0], x1[63:32]);
            my1 = prod(y1[31:0], x0[63:32]);
            t  = y0;
            y0 = swap_halves(y1);
            y1 = swap_halves(t);
            x0 -= blk.block_word2;
            x1 -= blk.block_word3;
            y0 += blk.block_word0;
            y1 += blk.block_word1;
            t  = x0;
            x0 = swap_halves(x1);
            x1 = swap_halves(t);
            x0 -= mx0;
            x1 -= mx1;
            y0 -= my0;
            y1 -= my1;
            if (!blk.last_block) begin
                open_msg = 1'b1;
                return;
            end
            mx0 = prod(x0[31:0], y1[63:32]);
            mx1 = prod(x1[31:0], y0[63:32]);
            my0 = prod(y0[31:0], x0[63:32]);
            my1 = prod(y1[31:0], x1[63:32]);
            fx0 = swap_halves(x1) + mx0;
            fx1 = swap_halves(x0) + mx1;
            fy0 = swap_halves(y1) - my0;
            fy1 = swap_halves(y0) - my1;
            h.hash_low  = fx0 ^ fy0;
            h.hash_high = fx1 ^ fy1;
            hash_q.push_back(h);
            load_seed();
            open_msg = 1'b0;
        endfunction

        function void check_hash(sbh_pkg::sbh_out_t got);
            sbh_pkg::sbh_out_t want;
            if (hash_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected hash beat, expected none, got low %h high %h",
                         $time, got.hash_low, got.hash_high);
                return;
            end
            want = hash_q.pop_front();
            if (got.hash_low !== want.hash_low) begin
                err_count++;
                $display("%0t: hash_low expected %h got %h", $time, want.hash_low, got.hash_low);
            end
            if (got.hash_high !== want.hash_high) begin
                err_count++;
                $display("%0t: hash_high expected %h got %h",
                         $time, want.hash_high, got.hash_high);
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    sbh_pkg::sbh_in_t                s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    sbh_pkg::sbh_out_t               m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sbh_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    word_t                           cfg_data  = '0;

    bit             calm_send = 1'b0;
    bit             calm_recv = 1'b0;
    hash_scoreboard sb;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    seeded_128bit_block_hash_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic word_t rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return word_t'(1) << $urandom_range(0, 63);
        if (r == 3) return ~(word_t'(1) << $urandom_range(0, 63));
        return {$urandom, $urandom};
    endfunction

    function automatic sbh_pkg::sbh_in_t pack_block(word_t w0, word_t w1, word_t w2,
                                                    word_t w3, logic last);
        sbh_pkg::sbh_in_t blk;
        blk.block_word0 = w0;
        blk.block_word1 = w1;
        blk.block_word2 = w2;
        blk.block_word3 = w3;
        blk.last_block  = last;
        return blk;
    endfunction

    task automatic send_block(input sbh_pkg::sbh_in_t blk);
        int gap;
        gap = calm_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= blk;
        do @(posedge aclk); while (!s_ready);
        sb.note_block(blk);
    endtask

    // Let every expected hash arrive, then hold while the pipeline empties.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.hash_q.size() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sbh_pkg::CFG_INDEX_W-1:0] idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_seed(idx, value);
    endtask

    task automatic write_seeds(input word_t sxl, input word_t sxh, input word_t syl,
                               input word_t syh);
        write_reg(sbh_pkg::REG_SEED_X_LOW, sxl);
        write_reg(sbh_pkg::REG_SEED_X_HIGH, sxh);
        write_reg(sbh_pkg::REG_SEED_Y_LOW, syl);
        write_reg(sbh_pkg::REG_SEED_Y_HIGH, syh);
        // out-of-range index: must be dropped
        if ($urandom_range(0, 1) == 1)
            write_reg(sbh_pkg::CFG_INDEX_W'($urandom_range(int'(sbh_pkg::REG_SEED_Y_HIGH) + 1,
                                            (1 << sbh_pkg::CFG_INDEX_W) - 1)), rand_word());
        cfg_valid <= 1'b0;
    endtask

    // Hash sink with random back-pressure.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_hash(m_data);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!calm_recv) stall = pick_gap();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int len;
        int r;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset seeds: empty string, all ones, then a three-beat message of edge patterns
        send_block(pack_block('0, '0, '0, '0, 1'b1));
        send_block(pack_block('1, '1, '1, '1, 1'b1));
        send_block(pack_block('0, '1, 64'd1, 64'h8000_0000_0000_0000, 1'b0));
        send_block(pack_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                              64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 1'b0));
        send_block(pack_block('1, '0, '1, '0, 1'b1));
        drain();

        write_seeds('1, '1, '1, '1);
        write_reg({sbh_pkg::CFG_INDEX_W{1'b1}}, '0);
        cfg_valid <= 1'b0;
        send_block(pack_block('0, '0, '0, '0, 1'b1));
        send_block(pack_block('1, '1, '1, '1, 1'b1));

        // seed change inside an open message applies to the next message only
        send_block(pack_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0));
        drain();
        write_seeds(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
        send_block(pack_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1));
        send_block(pack_block('0, '0, '0, '0, 1'b1));

        // back-to-back last beats against a stalling sink
        calm_send = 1'b1;
        repeat (4)
            send_block(pack_block(rand_word(), rand_word(), rand_word(), rand_word(), 1'b1));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                write_seeds('0, '0, '0, '0);
            else if (ph == 1)
                write_seeds('1, '1, '1, '1);
            else
                write_seeds(rand_word(), rand_word(), rand_word(), rand_word());
            calm_send = ($urandom_range(0, 3) == 0);
            calm_recv = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_BLOCKS) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    len = 1;
                else if (r < 85)
                    len = $urandom_range(2, 4);
                else
                    len = $urandom_range(5, 24);
                // a message cut at the phase end stays open across the seed writes
                for (int i = 0; i < len && sent < PHASE_BLOCKS; i++) begin
                    send_block(pack_block(rand_word(), rand_word(), rand_word(), rand_word(),
                                          i == len - 1));
                    sent++;
                end
            end
            drain();
        end

        calm_send = 1'b0;
        calm_recv = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.err_count == 0 && sb.hash_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/sbh_pkg.sv
src/sbh_seed_regs.sv
src/sbh_mix_stage.sv
src/sbh_final_stage.sv
src/seeded_128bit_block_hash_unit.sv
tb/sv/tb_top.sv
